// ===== rtl/obbsi_pkg.sv =====
// obbsi_pkg: types and constants for the oriented box / sphere closest-point test.
// Holds the transaction payload structs, register map and fixed-point widths.
// No dependencies.
package obbsi_pkg;

  // Fixed-point formats
  localparam int COORD_WIDTH    = 16;               // Q8.8 coordinates
  localparam int AXIS_FRAC_BITS = 14;               // Q1.14 axis components
  localparam int AXIS_WIDTH     = AXIS_FRAC_BITS + 2;
  localparam int RADIUS_WIDTH   = COORD_WIDTH - 1;

  // Configuration port
  localparam int REG_WIDTH   = 3 * COORD_WIDTH;
  localparam int DATA_WIDTH  = 64;
  localparam int ADDR_WIDTH  = 6;
  localparam int ADDR_LSB    = 3;                   // 8-byte register stride

  typedef enum logic [ADDR_WIDTH-ADDR_LSB-1:0] {
    REG_BOX_CENTER,
    REG_BOX_AXIS_A,
    REG_BOX_AXIS_B,
    REG_BOX_AXIS_C,
    REG_BOX_HALF_EXTENT
  } reg_idx_t;

  // Half extent reset: 1.0 in every field
  localparam logic [COORD_WIDTH-1:0] HALF_ONE = COORD_WIDTH'(1) << (COORD_WIDTH - 8);
  localparam logic [REG_WIDTH-1:0]   HALF_EXTENT_RESET = {3{HALF_ONE}};

  // Datapath widths
  localparam int DIFF_W  = COORD_WIDTH + 1;         // sphere - centre
  localparam int PROD_W  = DIFF_W + AXIS_WIDTH;     // d * axis
  localparam int DOT_W   = PROD_W + 2;              // sum of three products
  localparam int RND_W   = DOT_W - AXIS_FRAC_BITS;  // rounded projection
  localparam int DIST_W  = COORD_WIDTH + 1;         // clamped distance
  localparam int PT_W    = AXIS_WIDTH + DIST_W;     // axis * dist
  localparam int ACC_W   = PT_W + 2;                // centre + three terms
  localparam int NR_W    = ACC_W - AXIS_FRAC_BITS;  // rounded closest point
  localparam int V_W     = NR_W + 1;                // point - sphere
  localparam int SQ_W    = 2 * V_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int RR_W    = 2 * RADIUS_WIDTH;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0]  sphere_x;
    logic signed [COORD_WIDTH-1:0]  sphere_y;
    logic signed [COORD_WIDTH-1:0]  sphere_z;
    logic        [RADIUS_WIDTH-1:0] sphere_radius;
  } in_data_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] near_x;
    logic signed [COORD_WIDTH-1:0] near_y;
    logic signed [COORD_WIDTH-1:0] near_z;
  } out_data_t;

endpackage

// ===== rtl/obb_sphere_intersect.sv =====
// obb_sphere_intersect: closest-point test of a sphere against one oriented box.
// Seven-stage pipeline with APB-style register port.
// Depends on obbsi_pkg.
//
// Usage
//   The box (centre, three axes, three half widths) is written through the
//   APB-style port; registers lie at byte addresses 0, 8, 16, 24, 32 and are
//   48 bits wide in a 64-bit data word. pready is tied high, a write lands on
//   the access cycle. Write the box only while no transaction is in flight.
//   Sphere queries enter on the in_ channel, one transaction per cycle unless
//   in_stall is high; each yields exactly one result on the out_ channel,
//   in order. Each query passes through all seven register stages.
//   Throughput: one query per cycle while out_stall is low; every stage takes
//   a new transaction each cycle across the seven registered stages (subtract,
//   projection multiply, round and clamp, point multiply, accumulate and
//   round, square and saturate, distance compare).
//   Stall: each stage loads when it is empty or its successor moves, so a
//   stalled result holds in the output register while bubbles upstream
//   still fill; in_stall rises only once every stage is occupied.
//   Reset: rst_n (synchronous, active low) empties the pipeline and returns
//   the registers to their defaults: zero centre and axes, half widths 1.0.
module obb_sphere_intersect (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // query channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  obbsi_pkg::in_data_t                  in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output obbsi_pkg::out_data_t                 out_data,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [obbsi_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [obbsi_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [obbsi_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                                 pready
);

  localparam int CW    = obbsi_pkg::COORD_WIDTH;
  localparam int F     = obbsi_pkg::AXIS_FRAC_BITS;
  localparam int AXW   = obbsi_pkg::AXIS_WIDTH;
  localparam int RW    = obbsi_pkg::REG_WIDTH;
  localparam int NSTG  = 7;
  localparam int SAT_HI = (1 << (CW - 1)) - 1;
  localparam int SAT_LO = -(1 << (CW - 1));

  // ---------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------
  logic [RW-1:0] box_center_r;
  logic [RW-1:0] box_axis_r [3];
  logic [RW-1:0] box_half_r;
  logic          wr_en;
  logic [obbsi_pkg::ADDR_WIDTH-obbsi_pkg::ADDR_LSB-1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[obbsi_pkg::ADDR_WIDTH-1:obbsi_pkg::ADDR_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_center_r  <= '0;
      box_axis_r[0] <= '0;
      box_axis_r[1] <= '0;
      box_axis_r[2] <= '0;
      box_half_r    <= obbsi_pkg::HALF_EXTENT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        obbsi_pkg::REG_BOX_CENTER:      box_center_r  <= pwdata[RW-1:0];
        obbsi_pkg::REG_BOX_AXIS_A:      box_axis_r[0] <= pwdata[RW-1:0];
        obbsi_pkg::REG_BOX_AXIS_B:      box_axis_r[1] <= pwdata[RW-1:0];
        obbsi_pkg::REG_BOX_AXIS_C:      box_axis_r[2] <= pwdata[RW-1:0];
        obbsi_pkg::REG_BOX_HALF_EXTENT: box_half_r    <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      obbsi_pkg::REG_BOX_CENTER:      prdata = obbsi_pkg::DATA_WIDTH'(box_center_r);
      obbsi_pkg::REG_BOX_AXIS_A:      prdata = obbsi_pkg::DATA_WIDTH'(box_axis_r[0]);
      obbsi_pkg::REG_BOX_AXIS_B:      prdata = obbsi_pkg::DATA_WIDTH'(box_axis_r[1]);
      obbsi_pkg::REG_BOX_AXIS_C:      prdata = obbsi_pkg::DATA_WIDTH'(box_axis_r[2]);
      obbsi_pkg::REG_BOX_HALF_EXTENT: prdata = obbsi_pkg::DATA_WIDTH'(box_half_r);
      default:                        prdata = '0;
    endcase
  end

  // Unpacked register fields, x lowest. The user keeps them static while traffic flows; unchecked.
  logic signed [CW-1:0]  ctr  [3];
  logic signed [CW-1:0]  half [3];
  logic signed [AXW-1:0] ax   [3][3];   // [axis][component]

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ctr[k]  = $signed(box_center_r[k*CW +: CW]);
      half[k] = $signed(box_half_r[k*CW +: CW]);
      for (int i = 0; i < 3; i++) begin
        ax[i][k] = $signed(box_axis_r[i][k*AXW +: AXW]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: a stage loads when empty or when its successor moves
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int s = NSTG - 2; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int s = 1; s < NSTG; s++) begin
        if (adv[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] s_in [3];
  assign s_in[0] = in_data.sphere_x;
  assign s_in[1] = in_data.sphere_y;
  assign s_in[2] = in_data.sphere_z;

  // sphere centre travels alongside for the final distance
  logic signed [CW-1:0] s1_r [3], s2_r [3], s3_r [3], s4_r [3], s5_r [3];
  logic [obbsi_pkg::RADIUS_WIDTH-1:0] rad1_r;
  logic [obbsi_pkg::RR_W-1:0]         rr2_r, rr3_r, rr4_r, rr5_r, rr6_r;

  // stage 1: offset from box centre
  logic signed [obbsi_pkg::DIFF_W-1:0] d1_r [3];
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k] <= obbsi_pkg::DIFF_W'(s_in[k]) - obbsi_pkg::DIFF_W'(ctr[k]);
        s1_r[k] <= s_in[k];
      end
      rad1_r <= in_data.sphere_radius;
    end
  end

  // stage 2: projection products
  logic signed [obbsi_pkg::PROD_W-1:0] p2_r [3][3];
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          p2_r[i][k] <= obbsi_pkg::PROD_W'(d1_r[k]) * obbsi_pkg::PROD_W'(ax[i][k]);
        end
      end
      s2_r  <= s1_r;
      rr2_r <= obbsi_pkg::RR_W'(rad1_r) * obbsi_pkg::RR_W'(rad1_r);
    end
  end

  // stage 3: dot sum, round half up, clamp to +/- half width
  logic signed [obbsi_pkg::DOT_W-1:0]  dot3  [3];
  logic signed [obbsi_pkg::RND_W-1:0]  rnd3  [3];
  logic signed [obbsi_pkg::RND_W-1:0]  hx3   [3];
  logic signed [obbsi_pkg::RND_W-1:0]  cl3   [3];
  logic signed [obbsi_pkg::DIST_W-1:0] dist3_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot3[i] = obbsi_pkg::DOT_W'(p2_r[i][0]) + obbsi_pkg::DOT_W'(p2_r[i][1])
              + obbsi_pkg::DOT_W'(p2_r[i][2])
              + obbsi_pkg::DOT_W'(1 << (F - 1));
      rnd3[i] = $signed(dot3[i][obbsi_pkg::DOT_W-1:F]);
      hx3[i]  = obbsi_pkg::RND_W'(half[i]);
      // min against h first, then max against -h: a negative h gives -h
      cl3[i]  = (rnd3[i] > hx3[i]) ? hx3[i] : rnd3[i];
      if (cl3[i] < -hx3[i]) cl3[i] = -hx3[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        dist3_r[i] <= cl3[i][obbsi_pkg::DIST_W-1:0];
      end
      s3_r  <= s2_r;
      rr3_r <= rr2_r;
    end
  end

  // stage 4: step along each axis
  logic signed [obbsi_pkg::PT_W-1:0] q4_r [3][3];
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          q4_r[i][k] <= obbsi_pkg::PT_W'(ax[i][k]) * obbsi_pkg::PT_W'(dist3_r[i]);
        end
      end
      s4_r  <= s3_r;
      rr4_r <= rr3_r;
    end
  end

  // stage 5: accumulate from the scaled centre, round once
  logic signed [obbsi_pkg::ACC_W-1:0] acc5 [3];
  logic signed [obbsi_pkg::NR_W-1:0]  nr5_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc5[k] = (obbsi_pkg::ACC_W'(ctr[k]) <<< F)
              + obbsi_pkg::ACC_W'(q4_r[0][k]) + obbsi_pkg::ACC_W'(q4_r[1][k])
              + obbsi_pkg::ACC_W'(q4_r[2][k])
              + obbsi_pkg::ACC_W'(1 << (F - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int k = 0; k < 3; k++) begin
        nr5_r[k] <= $signed(acc5[k][obbsi_pkg::ACC_W-1:F]);
      end
      s5_r  <= s4_r;
      rr5_r <= rr4_r;
    end
  end

  // stage 6: squared offsets on the unsaturated point, saturate for output
  logic signed [obbsi_pkg::V_W-1:0]  v6   [3];
  logic signed [obbsi_pkg::SQ_W-1:0] sq6  [3];
  logic signed [CW-1:0]              sat6 [3];
  logic [obbsi_pkg::SQ_W-1:0]        sq6_r  [3];
  logic signed [CW-1:0]              near6_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v6[k]  = obbsi_pkg::V_W'(nr5_r[k]) - obbsi_pkg::V_W'(s5_r[k]);
      sq6[k] = obbsi_pkg::SQ_W'(v6[k]) * obbsi_pkg::SQ_W'(v6[k]);
      if (nr5_r[k] > SAT_HI)      sat6[k] = CW'(SAT_HI);
      else if (nr5_r[k] < SAT_LO) sat6[k] = CW'(SAT_LO);
      else                        sat6[k] = nr5_r[k][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int k = 0; k < 3; k++) begin
        sq6_r[k]   <= sq6[k];
        near6_r[k] <= sat6[k];
      end
      rr6_r <= rr5_r;
    end
  end

  // stage 7: distance compare into the output register
  logic [obbsi_pkg::SUM_W-1:0] dist2_7;
  obbsi_pkg::out_data_t        out_r;

  assign dist2_7 = obbsi_pkg::SUM_W'(sq6_r[0]) + obbsi_pkg::SUM_W'(sq6_r[1])
                 + obbsi_pkg::SUM_W'(sq6_r[2]);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      out_r.hit    <= (dist2_7 <= obbsi_pkg::SUM_W'(rr6_r));
      out_r.near_x <= near6_r[0];
      out_r.near_y <= near6_r[1];
      out_r.near_z <= near6_r[2];
    end
  end

  assign out_data = out_r;

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for obb_sphere_intersect, the sphere / oriented box test.
// Directed probes, then random boxes and spheres, checked against a closest-point predictor.
// Depends on obbsi_pkg and the obb_sphere_intersect RTL.
`timescale 1ns / 1ps

module testbench;
  import obbsi_pkg::*;

  localparam int IDLE_LIMIT = 1000;   // cycles with no transaction before giving up
  localparam int IN_W       = $bits(in_data_t);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_data_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_data_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr     = '0;
  logic [DATA_WIDTH-1:0] pwdata    = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  obb_sphere_intersect uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the box registers: centre, axes a/b/c, half widths (x in the low field).
  // Half widths come out of reset at 1.0 each, everything else at zero.
  logic [REG_WIDTH-1:0] box_cfg [5] = '{48'h0, 48'h0, 48'h0, 48'h0, 48'h0100_0100_0100};

  out_data_t nearest_due [$];         // expected results, oldest first
  int        spheres_sent = 0;
  int        results_seen = 0;
  int        hits_seen    = 0;
  int        boxes_used   = 0;
  int        fail_count   = 0;
  int        idle_cycles  = 0;
  bit        no_gaps      = 1'b0;     // both sides run flat out while set

  // ---------------------------------------------------------------------------
  // Directed box settings, indexed by the probe table's box column.
  // Box 0 is the reset state and is never written.
  // 1: unit axes, offset centre, unequal half widths
  // 2: axes of almost 2.0 so the closest point overruns and saturates
  // 3: box turned 45 degrees about z
  // 4: extreme axis components, negative and zero half widths
  // 5: axes of 0.5 so projections and the point land on rounding ties
  // 6: every register bit set
  // ---------------------------------------------------------------------------
  localparam logic [REG_WIDTH-1:0] BOX_PLAN [7][5] = '{
    '{48'h0, 48'h0, 48'h0, 48'h0, 48'h0100_0100_0100},
    '{48'h0080_FE00_0100, 48'h0000_0000_4000, 48'h0000_4000_0000,
      48'h4000_0000_0000, 48'h0080_0100_0200},
    '{48'h0000_C000_4000, 48'h0000_0000_7FFF, 48'h0000_7FFF_0000,
      48'h7FFF_0000_0000, 48'h0100_7FFF_7FFF},
    '{48'h0000_0000_0000, 48'h0000_2D41_2D41, 48'h0000_2D41_D2BF,
      48'h4000_0000_0000, 48'h0200_0100_0300},
    '{48'h0000_EDCB_1234, 48'h0001_8000_7FFF, 48'h8000_8000_8000,
      48'h7FFF_7FFF_7FFF, 48'h0000_FF00_8000},
    '{48'h0000_0000_0000, 48'h0000_0000_2000, 48'h0000_2000_0000,
      48'h2000_0000_0000, 48'h7FFF_7FFF_7FFF},
    '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
      48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF}
  };

  typedef struct {
    int        box;
    in_data_t  sphere;   // {x, y, z, radius}
    bit        known;    // want is typed in; otherwise the predictor decides
    out_data_t want;     // {hit, near_x, near_y, near_z}
  } probe_row_t;

  // Reset box: zero axes, so the closest point is always the origin and only
  // the radius test varies.
  probe_row_t probes [24] = '{
    '{0, {16'h0000, 16'h0000, 16'h0000, 15'h0000}, 1'b1, {1'b1, 48'h0}},  // zero radius, on point
    '{0, {16'h0100, 16'h0000, 16'h0000, 15'h0100}, 1'b1, {1'b1, 48'h0}},  // touching exactly
    '{0, {16'h0101, 16'h0000, 16'h0000, 15'h0100}, 1'b1, {1'b0, 48'h0}},  // one lsb clear
    '{0, {16'h7FFF, 16'h8000, 16'h7FFF, 15'h7FFF}, 1'b1, {1'b0, 48'h0}},  // far corner
    '{0, {16'h8000, 16'h0000, 16'h0000, 15'h7FFF}, 1'b1, {1'b0, 48'h0}},  // most negative x
    '{0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h0002}, 1'b1, {1'b1, 48'h0}},  // dist^2 3 <= 4
    '{1, {16'h0100, 16'hFE00, 16'h0080, 15'h0000}, 1'b0, '0},              // at the centre
    '{1, {16'h0400, 16'hFE00, 16'h0080, 15'h0100}, 1'b0, '0},              // touching +x face
    '{1, {16'hF000, 16'h1000, 16'h7FFF, 15'h7FFF}, 1'b0, '0},              // beyond a corner
    '{1, {16'h8000, 16'h8000, 16'h8000, 15'h0000}, 1'b0, '0},
    '{2, {16'h7FFF, 16'h8000, 16'h0000, 15'h7FFF}, 1'b0, '0},              // saturates both ways
    '{2, {16'h8000, 16'h7FFF, 16'h7FFF, 15'h0000}, 1'b0, '0},
    '{2, {16'h4000, 16'hC000, 16'h0000, 15'h0000}, 1'b0, '0},
    '{3, {16'h0200, 16'h0200, 16'h0000, 15'h0080}, 1'b0, '0},
    '{3, {16'h0500, 16'hFB00, 16'h0300, 15'h0200}, 1'b0, '0},
    '{3, {16'h0000, 16'h0000, 16'h0000, 15'h0000}, 1'b0, '0},
    '{4, {16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF}, 1'b0, '0},
    '{4, {16'h8000, 16'h8000, 16'h8000, 15'h7FFF}, 1'b0, '0},
    '{4, {16'h1234, 16'hEDCB, 16'h0000, 15'h0010}, 1'b0, '0},
    '{5, {16'h0001, 16'hFFFF, 16'h0003, 15'h0001}, 1'b0, '0},              // ties, both signs
    '{5, {16'hFFFD, 16'h0005, 16'hFFFF, 15'h0000}, 1'b0, '0},
    '{5, {16'h0000, 16'h0000, 16'h0000, 15'h7FFF}, 1'b0, '0},
    '{6, {16'h7FFF, 16'h8000, 16'h1234, 15'h5555}, 1'b0, '0},
    '{6, {16'h2AAA, 16'hD555, 16'hEDCB, 15'h2AAA}, 1'b0, '0}
  };

  // Rotation about z for random boxes: cos / sin of 0, 22.5, 45, 67.5 degrees in Q1.14
  localparam logic [15:0] COS_T [4] = '{16'h4000, 16'h3B21, 16'h2D41, 16'h187E};
  localparam logic [15:0] SIN_T [4] = '{16'h0000, 16'h187E, 16'h2D41, 16'h3B21};

  // Round a 2^-F scaled sum to the nearest coordinate, ties towards plus infinity.
  function automatic longint round_q(input longint x);
    return (x + (longint'(1) << (AXIS_FRAC_BITS - 1))) >>> AXIS_FRAC_BITS;
  endfunction

  // Closest point on the current box to the sphere centre, and the touch test.
  function automatic out_data_t closest_point(input in_data_t q);
    longint      s [3], c [3], h [3], ax [3][3], acc [3];
    longint      dot, reach, v, miss2, rad, top, bot;
    logic [15:0] near [3];
    out_data_t   r;
    s[0]  = $signed(q.sphere_x);
    s[1]  = $signed(q.sphere_y);
    s[2]  = $signed(q.sphere_z);
    rad   = q.sphere_radius;
    top   = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    bot   = -top - 1;
    miss2 = 0;
    for (int k = 0; k < 3; k++) begin
      c[k]   = $signed(box_cfg[REG_BOX_CENTER][k*COORD_WIDTH +: COORD_WIDTH]);
      h[k]   = $signed(box_cfg[REG_BOX_HALF_EXTENT][k*COORD_WIDTH +: COORD_WIDTH]);
      acc[k] = c[k] * (longint'(1) << AXIS_FRAC_BITS);
      for (int i = 0; i < 3; i++)
        ax[i][k] = $signed(box_cfg[REG_BOX_AXIS_A + i][k*AXIS_WIDTH +: AXIS_WIDTH]);
    end
    // project the offset on each axis, clamp to the half width (upper bound first),
    // then step that far along the axis
    for (int i = 0; i < 3; i++) begin
      dot = 0;
      for (int k = 0; k < 3; k++)
        dot += (s[k] - c[k]) * ax[i][k];
      reach = round_q(dot);
      if (reach > h[i])
        reach = h[i];
      if (reach < -h[i])
        reach = -h[i];
      for (int k = 0; k < 3; k++)
        acc[k] += ax[i][k] * reach;
    end
    // distance uses the unsaturated point; only the reported point saturates
    for (int k = 0; k < 3; k++) begin
      v = round_q(acc[k]);
      miss2 += (v - s[k]) * (v - s[k]);
      if (v > top)
        v = top;
      else if (v < bot)
        v = bot;
      near[k] = 16'(v);
    end
    r.hit    = (miss2 <= rad * rad);
    r.near_x = near[0];
    r.near_y = near[1];
    r.near_z = near[2];
    return r;
  endfunction

  // One register write: setup cycle, then access cycle; lands when pready is high.
  // The bus stays selected afterwards; the caller releases it.
  task automatic write_box_reg(input reg_idx_t idx, input logic [REG_WIDTH-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH'(idx) << ADDR_LSB;
    pwdata  <= {16'($urandom), val};   // bits above the fields are junk, ignored
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    box_cfg[idx] = val;
  endtask

  // Drain the pipe, then load a whole box.
  task automatic apply_box(input logic [REG_WIDTH-1:0] plan [5]);
    in_valid <= 1'b0;
    while (nearest_due.size() != 0)
      @(posedge clk);
    for (int i = 0; i < 5; i++)
      write_box_reg(reg_idx_t'(i), plan[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    boxes_used++;
  endtask

  // Present one query, sometimes after a random gap (none while no_gaps is set), and hold it until accepted.
  task automatic send_sphere(input in_data_t q, input bit known, input out_data_t want);
    if (!no_gaps && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (in_stall !== 1'b0);
    nearest_due.push_back(known ? want : closest_point(q));
    spheres_sent++;
  endtask

  // Random box: mostly a turned unit frame about a modest centre with small
  // half widths; now and then raw register contents.
  task automatic roll_box(output logic [REG_WIDTH-1:0] plan [5]);
    logic [15:0] cs, sn;
    logic [15:0] f [3];
    int          ang;
    for (int k = 0; k < 3; k++)
      f[k] = ($urandom_range(3) == 0) ? 16'($urandom)
                                      : 16'($urandom_range(0, 16'h4000) - 16'h2000);
    plan[REG_BOX_CENTER] = {f[2], f[1], f[0]};
    ang = $urandom_range(3);
    cs  = COS_T[ang];
    sn  = $urandom_range(1) ? -SIN_T[ang] : SIN_T[ang];
    plan[REG_BOX_AXIS_A] = {16'h0000, sn, cs};
    plan[REG_BOX_AXIS_B] = {16'h0000, cs, -sn};
    plan[REG_BOX_AXIS_C] = {16'h4000, 16'h0000, 16'h0000};
    for (int i = REG_BOX_AXIS_A; i <= REG_BOX_AXIS_C; i++)
      if ($urandom_range(4) == 0)
        plan[i] = REG_WIDTH'({$urandom, $urandom});
    for (int k = 0; k < 3; k++)
      f[k] = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0800));
    plan[REG_BOX_HALF_EXTENT] = {f[2], f[1], f[0]};
  endtask

  // Random sphere: mostly near the box centre so hits and misses both turn up,
  // sometimes any bit pattern at all.
  function automatic in_data_t roll_sphere(input int spread);
    in_data_t    q;
    logic [15:0] p [3];
    for (int k = 0; k < 3; k++)
      p[k] = box_cfg[REG_BOX_CENTER][k*COORD_WIDTH +: COORD_WIDTH]
             + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
    q = {p[0], p[1], p[2], 15'($urandom_range(0, 16'h0600))};
    if ($urandom_range(4) == 0)
      q = IN_W'({$urandom, $urandom});
    else if ($urandom_range(3) == 0)
      q.sphere_radius = 15'($urandom);
    return q;
  endfunction

  // Result side stalls at random, except during the flat-out phase.
  always @(posedge clk)
    out_stall <= !no_gaps && ($urandom_range(99) < 35);

  // Result checker: every accepted transaction pops the oldest expectation.
  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (out_data.hit === 1'b1)
        hits_seen++;
      if (nearest_due.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result: got %h", $time, out_data);
      end else begin
        want = nearest_due.pop_front();
        if (out_data !== want) begin
          fail_count++;
          if (out_data.hit !== want.hit)
            $display("%0t hit mismatch: expected %b, actual %b", $time, want.hit, out_data.hit);
          if (out_data.near_x !== want.near_x)
            $display("%0t near_x mismatch: expected %h, actual %h",
                     $time, want.near_x, out_data.near_x);
          if (out_data.near_y !== want.near_y)
            $display("%0t near_y mismatch: expected %h, actual %h",
                     $time, want.near_y, out_data.near_y);
          if (out_data.near_z !== want.near_z)
            $display("%0t near_z mismatch: expected %h, actual %h",
                     $time, want.near_z, out_data.near_z);
        end
      end
    end
  end

  // Watchdog: a hung handshake on either channel shows up as a long run of
  // cycles with no transaction anywhere.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL obb_sphere_intersect");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    logic [REG_WIDTH-1:0] plan [5];
    int                   cur_box;
    int                   spread;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed probes; the box is reloaded whenever the table moves to a new one
    cur_box = 0;
    foreach (probes[i]) begin
      if (probes[i].box != cur_box) begin
        apply_box(BOX_PLAN[probes[i].box]);
        cur_box = probes[i].box;
      end
      send_sphere(probes[i].sphere, probes[i].known, probes[i].want);
    end

    // random phases, a fresh box each; the third runs with no idling on either side
    for (int ph = 0; ph < 6; ph++) begin
      roll_box(plan);
      apply_box(plan);
      no_gaps = (ph == 2);
      spread  = $urandom_range(16'h0100, 16'h1000);
      repeat (125)
        send_sphere(roll_sphere(spread), 1'b0, '0);
      no_gaps = 1'b0;
    end

    in_valid <= 1'b0;
    while (nearest_due.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);   // pipe depth plus margin: catch any stray result

    $display("%0d sphere queries over %0d box settings, %0d directed", spheres_sent,
             boxes_used + 1, $size(probes));
    $display("%0d results checked, %0d of them hits, %0d failures", results_seen,
             hits_seen, fail_count);
    if (fail_count == 0)
      $display("PASS obb_sphere_intersect");
    else
      $display("FAIL obb_sphere_intersect");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/obbsi_pkg.sv
rtl/obb_sphere_intersect.sv
dv/testbench.sv
